// ===== sv/bmra_pkg.sv =====
package bmra_pkg;

	localparam int TABLE_DEPTH = 131072;
	localparam int IDX_W = 17;
	localparam int BEAM_W = 3;
	localparam int VAL_W = 32;
	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int ACC_W = 34;
	localparam int SUM_W = ACC_W + CNT_W;
	localparam int DEG_W = 25;
	localparam int DVS_W = (CNT_W > DEG_W) ? CNT_W : DEG_W;
	localparam int STEP_W = $clog2(SUM_W + 1);
	localparam int ENT_W = BEAM_W + VAL_W;

	localparam logic signed [ACC_W-1:0] DEG180 = ACC_W'(180 * 65536);
	localparam logic signed [ACC_W-1:0] DEG360 = ACC_W'(360 * 65536);

	localparam int FRAC_W = 16;
	localparam int DEGW_W = ACC_W - FRAC_W;
	localparam int TURN_DEG = 360;
	localparam int RECIP_SHIFT = 26;
	localparam logic [DEGW_W-1:0] RECIP_TURN =
		DEGW_W'(((1 << RECIP_SHIFT) + TURN_DEG - 1) / TURN_DEG);

	localparam logic FUNC_STORE = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WALK,
		ST_DRAIN,
		ST_DIVIDE,
		ST_FOLDCHK,
		ST_FOLD,
		ST_FINISH
	} bmra_state_t;

	typedef struct packed {
		logic              start;
		logic [STEP_W-1:0] steps;
	} div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_rsp_t;

endpackage

// ===== sv/bmra_channels.sv =====
interface bmra_cfg_if import bmra_pkg::*; ();
	logic valid;
	logic ready;
	logic angle_mode;

	modport source(output valid, output angle_mode, input ready);
	modport sink(input valid, input angle_mode, output ready);
endinterface

interface bmra_item_if import bmra_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic                     func;
	logic [IDX_W-1:0]         index;
	logic [BEAM_W-1:0]        beam_id;
	logic signed [VAL_W-1:0]  sample_value;
	logic [IDX_W-1:0]         span_end;

	modport source(output valid, output func, output index, output beam_id,
		output sample_value, output span_end, input ready);
	modport sink(input valid, input func, input index, input beam_id,
		input sample_value, input span_end, output ready);
endinterface

interface bmra_result_if import bmra_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [VAL_W-1:0]  mean_value;
	logic                     no_data;

	modport source(output valid, output mean_value, output no_data, input ready);
	modport sink(input valid, input mean_value, input no_data, output ready);
endinterface

// ===== sv/bmra_div.sv =====
module bmra_div import bmra_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  div_req_t         req,
	input  logic [SUM_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output div_rsp_t         rsp,
	output logic [SUM_W-1:0] quotient
);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] left_q;
	logic [SUM_W-1:0]  quo_q;
	logic [DVS_W-1:0]  rem_q;
	logic [DVS_W-1:0]  dvs_q;
	logic [DVS_W:0]    shifted;
	logic [DVS_W+1:0]  trial;
	logic              ge;
	logic [DVS_W-1:0]  rem_next;

	always_comb begin
		shifted = {rem_q, quo_q[SUM_W-1]};
		trial = {1'b0, shifted} - {2'b00, dvs_q};
		ge = !trial[DVS_W+1];
		rem_next = ge ? trial[DVS_W-1:0] : shifted[DVS_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			left_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				left_q <= req.steps;
			end else if (busy_q) begin
				left_q <= left_q - STEP_W'(1);
				if (left_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[SUM_W-2:0], ge};
			rem_q <= rem_next;
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign quotient = quo_q;

endmodule

// ===== sv/beam_matched_range_average.sv =====
// Beam-matched range averager.
// The items channel carries stores (func 0) and queries (func 1). A store writes
// one table entry and gives no result beat. A query walks its
// span through the table memory, one entry per cycle, accumulating the entries
// whose beam matches the first entry, then divides the sum by the count with a
// one-bit-per-cycle divider. The angle fold uses a reciprocal multiplication.
// In angle mode a mean below zero or above 360 degrees is folded back into range.
// Queries with no data skip the walk and the division.
// The block holds one item at a time.
// The result beat sits in an output register, so a store can be taken while a
// result waits; a query that finishes while the receiver stalls holds until the
// output register frees.
// The config channel writes angle_mode and is always ready.
// After reset the table is cleared one entry per cycle; no item is accepted
// until the clear is done.
module beam_matched_range_average import bmra_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	bmra_cfg_if.sink      cfg,
	bmra_item_if.sink     items,
	bmra_result_if.source results
);

	bmra_state_t state_q, state_d;

	logic [ENT_W-1:0] mem [TABLE_DEPTH];
	logic [ENT_W-1:0] rdata_s1;
	logic             mem_we;
	logic [AW-1:0]    mem_waddr;
	logic [ENT_W-1:0] mem_wdata;
	logic             rd_en;

	logic [AW-1:0] clr_q;
	logic [AW-1:0] addr_q;
	logic [AW-1:0] last_q;
	logic          first_q;
	logic          angle_q;

	logic                    v_s1, f_s1;
	logic [BEAM_W-1:0]       b_q;
	logic signed [VAL_W-1:0] v1_q;
	logic                    v_s2, m_s2;
	logic signed [ACC_W-1:0] adj_s2;
	logic signed [SUM_W-1:0] sum_q;
	logic [CNT_W-1:0]        cnt_q;
	logic                    neg_q;
	logic signed [ACC_W-1:0] mean_q;
	logic                    fneg_q;

	logic [1:0]          fph_q;
	logic [DEGW_W-1:0]   degw_q;
	logic [FRAC_W-1:0]   frac_q;
	logic [DEGW_W-1:0]   turns_q;
	logic [DEGW_W-1:0]   rdeg_q;
	logic [2*DEGW_W-1:0] prod_w;
	logic [DEGW_W-1:0]   turns_w;
	logic [DEGW_W-1:0]   rdeg_w;

	logic signed [VAL_W-1:0] res_mean_q;
	logic                    res_nd_q;
	logic                    out_valid_q;
	logic signed [VAL_W-1:0] out_mean_q;
	logic                    out_nd_q;

	logic [31:0] idx_w, end_w, end_cl;
	logic        in_range, nodata;
	logic [AW-1:0] last_a;

	logic [BEAM_W-1:0]       beam_s1;
	logic signed [VAL_W-1:0] val_s1;
	logic signed [ACC_W-1:0] vx_s1, ref_s1, d_s1, adj_d;
	logic                    match_s1;

	div_req_t         div_req;
	div_rsp_t         div_rsp;
	logic [SUM_W-1:0] div_dividend;
	logic [DVS_W-1:0] div_divisor;
	logic [SUM_W-1:0] div_quo;
	logic [SUM_W-1:0] sum_abs;
	logic [ACC_W-1:0] mean_abs;
	logic [ACC_W-1:0] qmag;
	logic signed [ACC_W-1:0] mean_d;
	logic signed [ACC_W-1:0] fold_d;
	logic [ACC_W-1:0] rem_x;
	logic             need_fold;
	logic             out_free;

	always_comb begin
		idx_w = 32'(items.index);
		end_w = 32'(items.span_end);
		in_range = idx_w < 32'(TABLE_DEPTH);
		end_cl = (end_w >= 32'(TABLE_DEPTH)) ? 32'(TABLE_DEPTH - 1) : end_w;
		last_a = AW'(end_cl);
		nodata = (idx_w == 32'd0) || !in_range || (end_cl < idx_w);
	end

	always_comb begin
		beam_s1 = rdata_s1[VAL_W +: BEAM_W];
		val_s1 = $signed(rdata_s1[VAL_W-1:0]);
		vx_s1 = ACC_W'(val_s1);
		ref_s1 = f_s1 ? vx_s1 : ACC_W'(v1_q);
		d_s1 = ref_s1 - vx_s1;
		match_s1 = f_s1 || (beam_s1 == b_q);
		adj_d = vx_s1;
		if (angle_q) begin
			if (d_s1 > DEG180) begin
				adj_d = vx_s1 + DEG360;
			end else if (d_s1 < -DEG180) begin
				adj_d = vx_s1 - DEG360;
			end
		end
	end

	always_comb begin
		sum_abs = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
		mean_abs = mean_q[ACC_W-1] ? ACC_W'(-mean_q) : ACC_W'(mean_q);
		qmag = div_quo[ACC_W-1:0];
		mean_d = neg_q ? -$signed(qmag) : $signed(qmag);
		need_fold = angle_q && ((mean_q > DEG360) || (mean_q < 0));
		prod_w = (2*DEGW_W)'(degw_q) * (2*DEGW_W)'(RECIP_TURN);
		turns_w = DEGW_W'(prod_w >> RECIP_SHIFT);
		rdeg_w = degw_q - turns_q * DEGW_W'(TURN_DEG);
		rem_x = {rdeg_q, frac_q};
		if (fneg_q) begin
			fold_d = (rem_x == '0) ? '0 : DEG360 - $signed(rem_x);
		end else begin
			fold_d = (rem_x == '0) ? DEG360 : $signed(rem_x);
		end
		out_free = !out_valid_q || results.ready;
	end

	always_comb begin
		state_d = state_q;
		mem_we = 1'b0;
		mem_waddr = AW'(items.index);
		mem_wdata = {items.beam_id, items.sample_value};
		rd_en = 1'b0;
		items.ready = 1'b0;
		div_req.start = 1'b0;
		div_req.steps = STEP_W'(SUM_W);
		div_dividend = sum_abs;
		div_divisor = DVS_W'(cnt_q);
		case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
				if (clr_q == AW'(TABLE_DEPTH - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				items.ready = 1'b1;
				if (items.valid) begin
					if (items.func == FUNC_STORE) begin
						mem_we = in_range;
					end else if (nodata) begin
						state_d = ST_FINISH;
					end else begin
						state_d = ST_WALK;
					end
				end
			end
			ST_WALK: begin
				rd_en = 1'b1;
				if (addr_q == last_q) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!v_s1 && !v_s2) begin
					div_req.start = 1'b1;
					state_d = ST_DIVIDE;
				end
			end
			ST_DIVIDE: begin
				if (div_rsp.done) begin
					state_d = ST_FOLDCHK;
				end
			end
			ST_FOLDCHK: begin
				if (need_fold) begin
					state_d = ST_FOLD;
				end else begin
					state_d = ST_FINISH;
				end
			end
			ST_FOLD: begin
				if (fph_q == 2'd2) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (rd_en) begin
			rdata_s1 <= mem[addr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			angle_q <= 1'b0;
			first_q <= 1'b0;
			v_s1 <= 1'b0;
			f_s1 <= 1'b0;
			v_s2 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
			if (cfg.valid) begin
				angle_q <= cfg.angle_mode;
			end
			if (state_q == ST_IDLE && items.valid && items.func == FUNC_QUERY) begin
				first_q <= 1'b1;
			end else if (rd_en) begin
				first_q <= 1'b0;
			end
			v_s1 <= rd_en;
			f_s1 <= rd_en && first_q;
			v_s2 <= v_s1;
			if (state_q == ST_FINISH && out_free) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && items.valid) begin
			addr_q <= AW'(items.index);
			last_q <= last_a;
			sum_q <= '0;
			cnt_q <= '0;
			res_mean_q <= '0;
			res_nd_q <= 1'b1;
		end else if (rd_en) begin
			addr_q <= addr_q + AW'(1);
		end
		if (v_s1 && f_s1) begin
			b_q <= beam_s1;
			v1_q <= val_s1;
		end
		adj_s2 <= adj_d;
		m_s2 <= match_s1;
		if (v_s2 && m_s2) begin
			sum_q <= sum_q + SUM_W'(adj_s2);
			cnt_q <= cnt_q + CNT_W'(1);
		end
		if (state_q == ST_DRAIN) begin
			neg_q <= sum_q[SUM_W-1];
		end
		if (state_q == ST_DIVIDE && div_rsp.done) begin
			mean_q <= mean_d;
		end
		if (state_q == ST_FOLDCHK) begin
			fneg_q <= mean_q[ACC_W-1];
			degw_q <= mean_abs[ACC_W-1:FRAC_W];
			frac_q <= mean_abs[FRAC_W-1:0];
			fph_q <= '0;
			res_nd_q <= 1'b0;
			res_mean_q <= VAL_W'(mean_q);
		end
		if (state_q == ST_FOLD) begin
			fph_q <= fph_q + 2'd1;
			turns_q <= turns_w;
			rdeg_q <= rdeg_w;
			if (fph_q == 2'd2) begin
				res_mean_q <= VAL_W'(fold_d);
			end
		end
		if (state_q == ST_FINISH && out_free) begin
			out_mean_q <= res_mean_q;
			out_nd_q <= res_nd_q;
		end
	end

	bmra_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (div_req),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.rsp       (div_rsp),
		.quotient  (div_quo)
	);

	assign cfg.ready = 1'b1;
	assign results.valid = out_valid_q;
	assign results.mean_value = out_mean_q;
	assign results.no_data = out_nd_q;

	a_no_write_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK || state_q == ST_DRAIN) |-> !mem_we)
		else $error("table written while a query walks its span");

	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start && state_q == ST_DRAIN |-> cnt_q != '0)
		else $error("division started with a zero count");

	a_done_in_divide: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> state_q == ST_DIVIDE)
		else $error("divider finished outside a division state");

	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> addr_q <= last_q)
		else $error("walk read past the end of the span");

	a_no_accept_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLEAR |=> !v_s1 && !out_valid_q)
		else $error("activity during the clearing pass");

endmodule
